// ===== rtl/array_linked_list_with_free_list_macros.svh =====
// Assertion macros for the linked list block checker.
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH

// Same-cycle implication, reset masked.
`define ALLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define ALLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alll_pkg.sv =====
// Types and constants shared by the linked list block.
`timescale 1ns / 1ps

package alll_pkg;

    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 7;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_SEEK,
        S_WALK,
        S_VREAD,
        S_PREVNXT,
        S_LINKPREV,
        S_UNLINK,
        S_RELEASE,
        S_RESP
    } t_state;

endpackage

// ===== rtl/alll_link_store.sv =====
// Next-link memory with the power-up sweep that threads the free list.
`timescale 1ns / 1ps

module alll_link_store #(
    parameter int NODE_COUNT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [$clog2(NODE_COUNT)-1:0]     i_waddr,
    input  logic [$clog2(NODE_COUNT+1)-1:0]   i_wdata,
    input  logic [$clog2(NODE_COUNT)-1:0]     i_raddr,
    output logic [$clog2(NODE_COUNT+1)-1:0]   o_rdata,
    output logic                              o_ready
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);

    logic [LW-1:0] r_mem [NODE_COUNT];
    logic [LW-1:0] r_rdata;
    logic [AW-1:0] r_idx;
    logic          r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_ready <= 1'b0;
        end else if (!r_ready) begin
            r_idx <= r_idx + AW'(1);
            if (r_idx == AW'(NODE_COUNT - 1)) begin
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ready) begin
            r_mem[r_idx] <= LW'(r_idx) + LW'(1);
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = r_ready;

endmodule

// ===== rtl/alll_value_store.sv =====
// Node data memory with registered read.
`timescale 1ns / 1ps

module alll_value_store #(
    parameter int NODE_COUNT = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(NODE_COUNT)-1:0]         i_waddr,
    input  logic signed [alll_pkg::VALUE_W-1:0]   i_wdata,
    input  logic [$clog2(NODE_COUNT)-1:0]         i_raddr,
    output logic signed [alll_pkg::VALUE_W-1:0]   o_rdata
);

    logic signed [alll_pkg::VALUE_W-1:0] r_mem [NODE_COUNT];
    logic signed [alll_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/array_linked_list_with_free_list.sv =====
// Top level: linked list in a node store with a free list, walked by a link sequencer.
`timescale 1ns / 1ps

// Command interface: an operation is taken when start is high and busy is low; its
// single result appears for exactly one cycle with o_strobe high and must be taken
// then, since the block cannot be held off. After reset the block stays busy while
// it threads every node onto the free list. The result of a read, insert or remove
// at position p is found by walking the list from its head: the sequencer follows one
// link per cycle through the registered read port of the link memory. A clear with n
// entries held passes through the unlink and release states once per entry, and a
// rejected operation goes straight to the result state. Busy drops in the cycle after
// each result, and the next operation can be taken then at the earliest.
module array_linked_list_with_free_list #(
    parameter int NODE_COUNT = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [alll_pkg::MODE_W-1:0]           i_mode,
    input  logic [alll_pkg::POS_W-1:0]            i_position,
    input  logic signed [alll_pkg::VALUE_W-1:0]   i_value_in,
    output logic                                  o_strobe,
    output logic                                  o_ok,
    output logic signed [alll_pkg::VALUE_W-1:0]   o_value_out,
    output logic [alll_pkg::LEN_W-1:0]            o_length,
    output logic                                  o_is_empty,
    output logic                                  o_is_full
);

    localparam int AW    = $clog2(NODE_COUNT);
    localparam int LW    = $clog2(NODE_COUNT + 1);
    localparam int PW    = alll_pkg::POS_W;
    localparam int CMP_W = (LW > PW) ? LW : PW;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    alll_pkg::t_state r_state, n_state;
    alll_pkg::t_mode  r_mode, n_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_old, n_old;
    logic [LW-1:0] r_fresh, n_fresh;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_count, n_count;
    logic          r_ok, n_ok;
    logic signed [alll_pkg::VALUE_W-1:0] r_word, n_word;

    logic                 link_we;
    logic [AW-1:0]        link_waddr;
    logic [LW-1:0]        link_wdata;
    logic [AW-1:0]        link_raddr;
    logic [LW-1:0]        link_rd;
    logic                 link_ready;
    logic                 val_we;
    logic [AW-1:0]        val_waddr;
    logic [AW-1:0]        val_raddr;
    logic signed [alll_pkg::VALUE_W-1:0] val_rd;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign pos_ext = CMP_W'(i_position);
    assign cnt_ext = CMP_W'(r_count);

    alll_link_store #(.NODE_COUNT(NODE_COUNT)) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rd),
        .o_ready (link_ready)
    );

    alll_value_store #(.NODE_COUNT(NODE_COUNT)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (i_value_in),
        .i_raddr (val_raddr),
        .o_rdata (val_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alll_pkg::S_SWEEP;
            r_head  <= NULL_LINK;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_pos   <= n_pos;
        r_rem   <= n_rem;
        r_cur   <= n_cur;
        r_old   <= n_old;
        r_fresh <= n_fresh;
        r_ok    <= n_ok;
        r_word  <= n_word;
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_rem      = r_rem;
        n_cur      = r_cur;
        n_old      = r_old;
        n_fresh    = r_fresh;
        n_head     = r_head;
        n_free     = r_free;
        n_count    = r_count;
        n_ok       = r_ok;
        n_word     = r_word;
        link_we    = 1'b0;
        link_waddr = r_cur[AW-1:0];
        link_wdata = r_free;
        link_raddr = r_cur[AW-1:0];
        val_we     = 1'b0;
        val_waddr  = r_free[AW-1:0];
        val_raddr  = r_cur[AW-1:0];

        unique case (r_state)
            alll_pkg::S_SWEEP: begin
                if (link_ready) begin
                    n_state = alll_pkg::S_IDLE;
                end
            end
            alll_pkg::S_IDLE: begin
                if (start) begin
                    n_mode  = alll_pkg::t_mode'(i_mode);
                    n_pos   = i_position;
                    n_ok    = 1'b0;
                    n_word  = '0;
                    n_state = alll_pkg::S_RESP;
                    unique case (alll_pkg::t_mode'(i_mode))
                        alll_pkg::MODE_INSERT: begin
                            if (pos_ext <= cnt_ext && r_free != NULL_LINK) begin
                                val_we     = 1'b1;
                                link_raddr = r_free[AW-1:0];
                                n_fresh    = r_free;
                                n_state    = alll_pkg::S_ALLOC;
                            end
                        end
                        alll_pkg::MODE_READ: begin
                            if (pos_ext < cnt_ext) begin
                                n_cur   = r_head;
                                n_rem   = i_position;
                                n_state = alll_pkg::S_SEEK;
                            end
                        end
                        alll_pkg::MODE_REMOVE: begin
                            if (pos_ext < cnt_ext) begin
                                if (i_position == '0) begin
                                    n_old      = r_head;
                                    link_raddr = r_head[AW-1:0];
                                    val_raddr  = r_head[AW-1:0];
                                    n_state    = alll_pkg::S_UNLINK;
                                end else begin
                                    n_cur   = r_head;
                                    n_rem   = i_position - PW'(1);
                                    n_state = alll_pkg::S_SEEK;
                                end
                            end
                        end
                        alll_pkg::MODE_CLEAR: begin
                            if (r_count == '0) begin
                                n_ok = 1'b1;
                            end else begin
                                n_old      = r_head;
                                link_raddr = r_head[AW-1:0];
                                n_state    = alll_pkg::S_UNLINK;
                            end
                        end
                        default: begin
                            n_state = alll_pkg::S_RESP;
                        end
                    endcase
                end
            end
            alll_pkg::S_ALLOC: begin
                n_free = link_rd;
                if (r_pos == '0) begin
                    link_we    = 1'b1;
                    link_waddr = r_fresh[AW-1:0];
                    link_wdata = r_head;
                    n_head     = r_fresh;
                    n_count    = r_count + LW'(1);
                    n_ok       = 1'b1;
                    n_state    = alll_pkg::S_RESP;
                end else begin
                    n_cur   = r_head;
                    n_rem   = r_pos - PW'(1);
                    n_state = alll_pkg::S_SEEK;
                end
            end
            alll_pkg::S_SEEK: begin
                if (r_rem == '0) begin
                    if (r_mode == alll_pkg::MODE_READ) begin
                        n_state = alll_pkg::S_VREAD;
                    end else begin
                        n_state = alll_pkg::S_PREVNXT;
                    end
                end else begin
                    n_state = alll_pkg::S_WALK;
                end
            end
            alll_pkg::S_WALK: begin
                n_cur = link_rd;
                n_rem = r_rem - PW'(1);
                if (r_rem == PW'(1)) begin
                    n_state = alll_pkg::S_SEEK;
                end else begin
                    link_raddr = link_rd[AW-1:0];
                end
            end
            alll_pkg::S_VREAD: begin
                n_word  = val_rd;
                n_ok    = 1'b1;
                n_state = alll_pkg::S_RESP;
            end
            alll_pkg::S_PREVNXT: begin
                if (r_mode == alll_pkg::MODE_INSERT) begin
                    link_we    = 1'b1;
                    link_waddr = r_fresh[AW-1:0];
                    link_wdata = link_rd;
                    n_state    = alll_pkg::S_LINKPREV;
                end else begin
                    n_old      = link_rd;
                    link_raddr = link_rd[AW-1:0];
                    val_raddr  = link_rd[AW-1:0];
                    n_state    = alll_pkg::S_UNLINK;
                end
            end
            alll_pkg::S_LINKPREV: begin
                link_we    = 1'b1;
                link_waddr = r_cur[AW-1:0];
                link_wdata = r_fresh;
                n_count    = r_count + LW'(1);
                n_ok       = 1'b1;
                n_state    = alll_pkg::S_RESP;
            end
            alll_pkg::S_UNLINK: begin
                if (r_mode != alll_pkg::MODE_CLEAR) begin
                    n_word = val_rd;
                end
                if (r_mode == alll_pkg::MODE_REMOVE && r_pos != '0) begin
                    link_we    = 1'b1;
                    link_waddr = r_cur[AW-1:0];
                    link_wdata = link_rd;
                end else begin
                    n_head = link_rd;
                end
                n_state = alll_pkg::S_RELEASE;
            end
            alll_pkg::S_RELEASE: begin
                link_we    = 1'b1;
                link_waddr = r_old[AW-1:0];
                link_wdata = r_free;
                n_free     = r_old;
                n_count    = r_count - LW'(1);
                if (r_mode == alll_pkg::MODE_CLEAR && r_count != LW'(1)) begin
                    n_old      = r_head;
                    link_raddr = r_head[AW-1:0];
                    n_state    = alll_pkg::S_UNLINK;
                end else begin
                    n_ok    = 1'b1;
                    n_state = alll_pkg::S_RESP;
                end
            end
            alll_pkg::S_RESP: begin
                n_state = alll_pkg::S_IDLE;
            end
            default: begin
                n_state = alll_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != alll_pkg::S_IDLE);
    assign o_strobe    = (r_state == alll_pkg::S_RESP);
    assign o_ok        = r_ok;
    assign o_value_out = r_word;
    assign o_length    = alll_pkg::LEN_W'(r_count);
    assign o_is_empty  = (r_count == '0);
    assign o_is_full   = (r_free == NULL_LINK);

endmodule

// ===== rtl/alll_checker.sv =====
// Port-level checker for the linked list block, bound to the top level.
`timescale 1ns / 1ps
`include "array_linked_list_with_free_list_macros.svh"

module alll_checker #(
    parameter int NODE_COUNT = 64
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  o_strobe,
    input logic                                  o_ok,
    input logic signed [alll_pkg::VALUE_W-1:0]   o_value_out,
    input logic [alll_pkg::LEN_W-1:0]            o_length,
    input logic                                  o_is_empty
);

    localparam logic [alll_pkg::LEN_W-1:0] MAX_LEN = alll_pkg::LEN_W'(NODE_COUNT);

    `ALLL_ASSERT_NOW(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "result outside a transaction")
    `ALLL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "transaction not held")
    `ALLL_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_strobe && !o_ok, o_value_out == '0, "reject with data")
    `ALLL_ASSERT_NOW(a_empty_len, i_clk, i_rst_n, o_strobe && (NODE_COUNT < 128), (o_is_empty == (o_length == '0)) && (o_length <= MAX_LEN), "length flags disagree")

endmodule

bind array_linked_list_with_free_list alll_checker #(.NODE_COUNT(NODE_COUNT)) u_alll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_ok        (o_ok),
    .o_value_out (o_value_out),
    .o_length    (o_length),
    .o_is_empty  (o_is_empty)
);
